### rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, constants and helper functions for the capture pattern checker.
// ----------------------------------------------------------------------------
package cpc_pkg;

	// Check mode codes. The unused fourth code behaves as PRBS.
	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_RAMP   = 2'd1,
		MODE_PRBS   = 2'd2
	} check_mode_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_CHECK_MODE = 1'b0,
		CFG_START_SEED = 1'b1
	} cfg_index_t;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [WORD_W-1:0] PRBS_DEFAULT_SEED = 32'h1ace_beef;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'd4095;
	localparam logic [WORD_W-1:0] REPORT_LIMIT = 32'd8;
	localparam logic [WORD_W-1:0] COUNT_MAX = '1;

	// Running state of the check.
	typedef struct packed {
		logic [WORD_W-1:0] expected_value;
		logic [WORD_W-1:0] position;
		logic [WORD_W-1:0] error_total;
	} check_state_t;

	// Result of one element.
	typedef struct packed {
		logic              mismatch;
		logic              report;
		logic [WORD_W-1:0] element_index;
		logic [WORD_W-1:0] expected_word;
		logic [WORD_W-1:0] error_count;
	} check_result_t;

	// One step of the shift-left LFSR with taps 31, 21, 1 and 0.
	function automatic logic [WORD_W-1:0] lfsr_advance(input logic [WORD_W-1:0] v);
		logic fb;
		fb = v[31] ^ v[21] ^ v[1] ^ v[0];
		return {v[WORD_W-2:0], fb};
	endfunction

endpackage

### rtl/capture_pattern_checker.sv
// ----------------------------------------------------------------------------
// capture_pattern_checker
// Checks a captured stream against a sample range, a ramp or a PRBS sequence.
// ----------------------------------------------------------------------------
// The checker takes one element per clock while the result side does not
// stall and returns one result per element: the element sits in the input
// register, then the check logic writes the result register and the running
// state in the same cycle, so consecutive elements flow without gaps.
// Throughput is set by that single state update per cycle; stalls on the
// result side hold the input register and then back-pressure the input.
// Write check_mode and start_seed only while no element is in flight; a seed
// takes effect at the next element flagged as the start of a capture.
module capture_pattern_checker
	import cpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [WORD_W-1:0]      data_word,
	input  logic                   start_req,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   mismatch,
	output logic                   report,
	output logic [WORD_W-1:0]      element_index,
	output logic [WORD_W-1:0]      expected_word,
	output logic [WORD_W-1:0]      error_count
);

	logic [MODE_W-1:0] check_mode_q;
	logic [WORD_W-1:0] start_seed_q;
	check_state_t      state_q;
	check_state_t      state_nxt;
	check_result_t     result;
	check_result_t     result_s2;
	logic              valid_s2;
	logic              valid_s1;
	logic [WORD_W-1:0] data_s1;
	logic              start_s1;
	logic              advance_s1;
	logic              take_in;

	// Handshake: stage 1 moves on when the result register is free or drained.
	assign advance_s1 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign take_in    = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q <= MODE_SAMPLE;
			start_seed_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_CHECK_MODE: check_mode_q <= cfg_data[MODE_W-1:0];
				CFG_START_SEED: start_seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1  <= data_word;
			start_s1 <= start_req;
		end
	end

	cpc_core u_core (
		.check_mode (check_mode_q),
		.start_seed (start_seed_q),
		.data_word  (data_s1),
		.start_req  (start_s1),
		.state_cur  (state_q),
		.state_nxt  (state_nxt),
		.result     (result)
	);

	// Running state and result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance_s1) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign mismatch      = result_s2.mismatch;
	assign report        = result_s2.report;
	assign element_index = result_s2.element_index;
	assign expected_word = result_s2.expected_word;
	assign error_count   = result_s2.error_count;

	// A report is only raised for a mismatching element.
	a_report_needs_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report |-> mismatch)
		else $error("report without mismatch");

	// A mismatch is always counted.
	a_mismatch_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mismatch |-> (error_count != '0))
		else $error("mismatch with zero error count");

	// Reports stop after the first eight errors.
	a_report_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report |-> (error_count <= REPORT_LIMIT))
		else $error("report beyond limit");

	// The running state changes only when an element is checked.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance_s1 |=> $stable(state_q))
		else $error("state changed without an element");

endmodule

### rtl/cpc_core.sv
// ----------------------------------------------------------------------------
// cpc_core
// Combinational check of one element: applies a start, compares the element
// against the current mode's expectation and forms the next state.
// ----------------------------------------------------------------------------
module cpc_core
	import cpc_pkg::*;
(
	input  logic [MODE_W-1:0] check_mode,
	input  logic [WORD_W-1:0] start_seed,
	input  logic [WORD_W-1:0] data_word,
	input  logic              start_req,
	input  check_state_t      state_cur,
	output check_state_t      state_nxt,
	output check_result_t     result
);

	logic              prbs;
	logic              sample;
	logic [WORD_W-1:0] exp_base;
	logic [WORD_W-1:0] pos_base;
	logic [WORD_W-1:0] err_base;
	logic              bad;

	// A start reloads the expected value and clears the counters first.
	always_comb begin
		prbs   = check_mode[1];
		sample = (check_mode == MODE_SAMPLE);
		if (start_req) begin
			exp_base = (prbs && (start_seed == '0)) ? PRBS_DEFAULT_SEED : start_seed;
			pos_base = '0;
			err_base = '0;
		end else begin
			exp_base = state_cur.expected_value;
			pos_base = state_cur.position;
			err_base = state_cur.error_total;
		end
	end

	// Compare and advance.
	always_comb begin
		if (sample) begin
			bad = (data_word[SAMPLE_W-1:0] > SAMPLE_MAX);
			state_nxt.expected_value = exp_base;
			result.expected_word = '0;
		end else begin
			bad = (data_word != exp_base);
			state_nxt.expected_value = prbs ? lfsr_advance(exp_base) : exp_base + 1'b1;
			result.expected_word = exp_base;
		end
		state_nxt.position = pos_base + 1'b1;
		state_nxt.error_total = (bad && (err_base != COUNT_MAX)) ? err_base + 1'b1 : err_base;
		result.mismatch = bad;
		result.report = bad && (err_base < REPORT_LIMIT);
		result.element_index = pos_base;
		result.error_count = state_nxt.error_total;
	end

endmodule

### dv/capture_pattern_checker_test.sv
// ----------------------------------------------------------------------------
// capture_pattern_checker_test
// Self-checking testbench for the capture pattern checker.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the check state and configuration.
// For every accepted element it works out the mismatch and report flags, the
// element index, the expected word and the error count. Each accepted result
// is compared with the oldest prediction.
// Stimulus starts with a short directed set:
// - the sample range boundary;
// - checking before any start;
// - the default PRBS seed;
// - the unused mode code;
// - ramp wrap-around;
// - the report limit.
// It then runs random capture phases. Most of them carry well-formed ramp or
// PRBS sequences with a few corrupted words. Both sides idle and stall at
// random. One phase holds the result side off for a long stretch, so that the
// input side fills up and stalls.
// ----------------------------------------------------------------------------
module capture_pattern_checker_test
	import cpc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// The fourth mode code has no package name; it must behave as PRBS.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 370;
	localparam int unsigned HOLD_CYCLES = 80;

	// Scoreboard: predicts each element's result and checks the block's output.
	class pattern_scoreboard;
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] seed;
		logic [WORD_W-1:0] expected_value;
		logic [WORD_W-1:0] position;
		logic [WORD_W-1:0] error_total;
		check_result_t     result_q[$];
		int unsigned       failures;
		int unsigned       checked;
		int unsigned       flagged;

		function new();
			mode = MODE_SAMPLE;
			seed = '0;
			expected_value = '0;
			position = '0;
			error_total = '0;
			failures = 0;
			checked = 0;
			flagged = 0;
		endfunction

		// Track a configuration write.
		function void set_reg(cfg_index_t idx, logic [WORD_W-1:0] data);
			if (idx == CFG_CHECK_MODE) begin
				mode = data[MODE_W-1:0];
			end else begin
				seed = data;
			end
		endfunction

		// Shift-left LFSR step with taps 31, 21, 1 and 0.
		function logic [WORD_W-1:0] lfsr_step(logic [WORD_W-1:0] v);
			logic fb;
			fb = ^{v[31], v[21], v[1], v[0]};
			return {v[WORD_W-2:0], fb};
		endfunction

		// Word that the next element is compared against in ramp or PRBS mode.
		function logic [WORD_W-1:0] upcoming_word(logic start);
			if (start) begin
				return (mode[1] && seed == '0) ? PRBS_DEFAULT_SEED : seed;
			end
			return expected_value;
		endfunction

		// Predict the result of an accepted element and queue it.
		function void note_item(logic [WORD_W-1:0] data, logic start);
			check_result_t r;
			logic bad;
			if (start) begin
				expected_value = upcoming_word(1'b1);
				position = '0;
				error_total = '0;
			end
			if (mode == MODE_SAMPLE) begin
				bad = data[SAMPLE_W-1:0] > SAMPLE_MAX;
				r.expected_word = '0;
			end else begin
				bad = data != expected_value;
				r.expected_word = expected_value;
				expected_value = mode[1] ? lfsr_step(expected_value) : expected_value + 1'b1;
			end
			r.mismatch = bad;
			r.report = bad && error_total < REPORT_LIMIT;
			if (bad && error_total != COUNT_MAX) begin
				error_total = error_total + 1'b1;
			end
			r.element_index = position;
			r.error_count = error_total;
			position = position + 1'b1;
			if (bad) begin
				flagged++;
			end
			result_q.push_back(r);
		endfunction

		// Compare an accepted result with the oldest prediction.
		function void check_result(check_result_t got);
			check_result_t want;
			if (result_q.size() == 0) begin
				$error("result with no element outstanding");
				failures++;
				return;
			end
			want = result_q.pop_front();
			checked++;
			if (got.mismatch !== want.mismatch) begin
				$error("mismatch: expected %0h, actual %0h", want.mismatch, got.mismatch);
				failures++;
			end
			if (got.report !== want.report) begin
				$error("report: expected %0h, actual %0h", want.report, got.report);
				failures++;
			end
			if (got.element_index !== want.element_index) begin
				$error("element_index: expected %0h, actual %0h",
					want.element_index, got.element_index);
				failures++;
			end
			if (got.expected_word !== want.expected_word) begin
				$error("expected_word: expected %0h, actual %0h",
					want.expected_word, got.expected_word);
				failures++;
			end
			if (got.error_count !== want.error_count) begin
				$error("error_count: expected %0h, actual %0h",
					want.error_count, got.error_count);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return result_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [WORD_W-1:0]      data_word = '0;
	logic                   start_req = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   mismatch;
	logic                   report;
	logic [WORD_W-1:0]      element_index;
	logic [WORD_W-1:0]      expected_word;
	logic [WORD_W-1:0]      error_count;

	pattern_scoreboard sb = new();
	bit                no_idle = 1'b0;
	bit                hold_req = 1'b0;
	int unsigned       items_sent = 0;
	int unsigned       settings_used = 0;

	capture_pattern_checker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_word    (data_word),
		.start_req    (start_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mismatch     (mismatch),
		.report       (report),
		.element_index(element_index),
		.expected_word(expected_word),
		.error_count  (error_count)
	);

	always #1 clk = ~clk;

	// Idle stretches: mostly short, now and then a long one.
	function automatic int unsigned idle_len();
		if ($urandom_range(99) < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Offer one element after an optional gap and wait until it is taken.
	task automatic send_item(logic [WORD_W-1:0] data, logic start);
		int unsigned gap;
		gap = (no_idle || $urandom_range(99) < 65) ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= data;
		start_req <= start;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_item(data, start);
		items_sent++;
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write both registers; only called while nothing is in flight.
	task automatic configure(logic [MODE_W-1:0] mode, logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] mode_data;
		mode_data = $urandom();
		mode_data[MODE_W-1:0] = mode;
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHECK_MODE;
		cfg_data <= mode_data;
		@(posedge clk);
		sb.set_reg(CFG_CHECK_MODE, mode_data);
		cfg_index <= CFG_START_SEED;
		cfg_data <= seed;
		@(posedge clk);
		sb.set_reg(CFG_START_SEED, seed);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Build an element: correct for the current mode unless picked as an error.
	function automatic logic [WORD_W-1:0] make_word(logic start, int unsigned err_pct);
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] want;
		w = $urandom();
		if (sb.mode == MODE_SAMPLE) begin
			if ($urandom_range(99) < err_pct) begin
				w[SAMPLE_W-1:0] = SAMPLE_W'($urandom_range(4096, 65535));
			end else begin
				w[SAMPLE_W-1:0] = SAMPLE_W'($urandom_range(0, 4095));
			end
		end else begin
			want = sb.upcoming_word(start);
			if ($urandom_range(99) >= err_pct) begin
				w = want;
			end else if ($urandom_range(1) != 0) begin
				w = want ^ (32'd1 << $urandom_range(31));
			end
		end
		return w;
	endfunction

	// One capture: optional start on the first element, rare restarts later.
	task automatic run_capture(int unsigned count, int unsigned err_pct, bit start_first);
		logic start;
		for (int unsigned i = 0; i < count; i++) begin
			start = (i == 0 && start_first) || $urandom_range(99) < 2;
			send_item(make_word(start, err_pct), start);
		end
	endtask

	// Result side: check accepted results and stall at random or on request.
	initial begin : result_side
		int unsigned stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result({mismatch, report, element_index, expected_word, error_count});
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(99) < 25) begin
				stall_left = idle_len() - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Main sequence.
	initial begin : stimulus
		int unsigned random_sent;
		int unsigned r;
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] seed;
		int unsigned err_pct;
		int unsigned count;

		random_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Sample mode from reset: range boundary, upper bits ignored.
		send_item(32'h0000_0fff, 1'b0);
		send_item(32'h0000_1000, 1'b0);
		send_item(32'hffff_0000, 1'b0);
		send_item(32'hffff_ffff, 1'b0);

		// PRBS with no start yet: the all-zero register stays at zero.
		drain();
		configure(MODE_PRBS, 32'hffff_ffff);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_0001, 1'b0);

		// Zero seed selects the default PRBS seed.
		drain();
		configure(MODE_PRBS, 32'h0000_0000);
		send_item(sb.upcoming_word(1'b1), 1'b1);
		send_item(sb.upcoming_word(1'b0), 1'b0);
		send_item(sb.upcoming_word(1'b0), 1'b0);
		send_item(sb.upcoming_word(1'b0) ^ 32'h1, 1'b0);

		// The unused mode code runs the PRBS check.
		drain();
		configure(MODE_UNUSED, 32'hffff_ffff);
		send_item(sb.upcoming_word(1'b1), 1'b1);
		send_item(sb.upcoming_word(1'b0), 1'b0);
		send_item(sb.upcoming_word(1'b0), 1'b0);

		// Ramp wraps past all-ones, then nine errors cross the report limit.
		drain();
		configure(MODE_RAMP, 32'hffff_ffff);
		send_item(32'hffff_ffff, 1'b1);
		send_item(32'h0000_0000, 1'b0);
		repeat (9) send_item(sb.upcoming_word(1'b0) ^ 32'h8000_0000, 1'b0);

		// Long hold-off on the result side while elements keep coming.
		drain();
		configure(MODE_RAMP, $urandom());
		no_idle = 1'b1;
		hold_req = 1'b1;
		run_capture(60, 3, 1'b1);
		random_sent += 60;

		// Random phases; a phase without a start continues the old capture.
		while (random_sent < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 25) begin
				mode = MODE_SAMPLE;
			end else if (r < 55) begin
				mode = MODE_RAMP;
			end else if (r < 88) begin
				mode = MODE_PRBS;
			end else begin
				mode = MODE_UNUSED;
			end
			r = $urandom_range(99);
			if (r < 15) begin
				seed = '0;
			end else if (r < 25) begin
				seed = '1;
			end else begin
				seed = $urandom();
			end
			r = $urandom_range(99);
			if (r < 40) begin
				err_pct = 0;
			end else if (r < 75) begin
				err_pct = 3;
			end else if (r < 92) begin
				err_pct = 20;
			end else begin
				err_pct = 100;
			end
			drain();
			configure(mode, seed);
			no_idle = ($urandom_range(99) < 20);
			count = $urandom_range(10, 50);
			run_capture(count, err_pct, $urandom_range(99) < 85);
			random_sent += count;
		end

		// Let everything come back, then keep watching for stray results.
		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.failures++;
		end
		$display("Covered %0d elements over %0d register settings in all four mode codes.",
			items_sent, settings_used);
		$display("Checked %0d results, %0d of them pattern errors, %0d field failures.",
			sb.checked, sb.flagged, sb.failures);
		if (sb.failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#400000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
